// ----- rtl/core/rtm_pkg.sv -----
package rtm_pkg;

	// Field widths of the event and snapshot channels.
	localparam int unsigned REQ_W     = 4;
	localparam int unsigned WORD_W    = 32;
	localparam int unsigned STALE_W   = 8;
	localparam int unsigned IN_DATA_W = 64;
	localparam int unsigned OUT_DATA_W = 296;

	// Depth of the queue between decode and execution.
	localparam int unsigned QUEUE_DEPTH = 2;
	localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
	localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

	// Configuration register indexes.
	localparam logic REG_OVERRUN_LIMIT = 1'b0;
	localparam logic REG_STALE_LIMIT   = 1'b1;

	// Reset values of the configuration registers.
	localparam logic [WORD_W-1:0]  OVERRUN_LIMIT_RST = 32'd168000;
	localparam logic [STALE_W-1:0] STALE_LIMIT_RST   = 8'd3;

	// Event request codes as they arrive on the input channel.
	localparam logic [REQ_W-1:0] REQ_START    = 4'd0;
	localparam logic [REQ_W-1:0] REQ_STOP     = 4'd1;
	localparam logic [REQ_W-1:0] REQ_TICK     = 4'd2;
	localparam logic [REQ_W-1:0] REQ_LINE     = 4'd3;
	localparam logic [REQ_W-1:0] REQ_MISMATCH = 4'd4;
	localparam logic [REQ_W-1:0] REQ_MARKER   = 4'd5;
	localparam logic [REQ_W-1:0] REQ_REF_RST  = 4'd6;
	localparam logic [REQ_W-1:0] REQ_ISR_END  = 4'd7;
	localparam logic [REQ_W-1:0] REQ_IMU_TIME = 4'd8;
	localparam logic [REQ_W-1:0] REQ_IMU_ERR  = 4'd9;

	// Internal operation after decode.
	typedef enum logic [3:0] {
		OP_NONE,
		OP_START,
		OP_STOP,
		OP_TICK,
		OP_LINE,
		OP_MISMATCH,
		OP_MARKER,
		OP_REF_RST,
		OP_ISR_END,
		OP_IMU_TIME,
		OP_IMU_ERR
	} op_t;

	// One decoded command as it sits in the queue.
	typedef struct packed {
		op_t               op;
		logic              over_limit;
		logic [WORD_W-1:0] pulse;
		logic [WORD_W-1:0] cycles;
	} cmd_t;

endpackage

// ----- rtl/core/run_timing_monitor.sv -----
// Run-timing diagnostics monitor.
// Input channel (s_*): one event request per transfer. s_tuser carries the
// request type, s_tdata the encoder pulse count and the measured cycle count.
// Output channel (m_*): one snapshot of all diagnostics per event, taken after
// the event was applied, plus the line-fresh and active flags.
// Configuration: cfg_we writes cfg_data into register cfg_index at the clock
// edge (0 overrun limit in cycles, 1 stale limit in ticks, low 8 bits).
// The user must write the registers only while no event is in flight; the block does not enforce it.
// With the queue empty and the output register free, a taken request is written
// into the queue, executed from its head and held in the output register on m_tvalid.
// Throughput: one event per cycle while m_tready stays high; each event is one
// compare-and-update of the state registers in the execution stage.
// A two-entry queue separates decode from execution, so a request is still
// taken while a result waits on m_tready. When the receiver stalls, the
// result stays in the output register and the queue fills; s_tready drops
// once it is full.
// Reset: the monitor is stopped, all counters and maxima are zero and both
// configuration registers return to their defaults (168000 and 3).
module run_timing_monitor #(
	parameter int COUNT_BITS = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// [31:0] pulse, [63:32] cycles
	input  logic [rtm_pkg::IN_DATA_W-1:0]     s_tdata,
	// [3:0] req_type
	input  logic [rtm_pkg::REQ_W-1:0]         s_tuser,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// [31:0] max_line_interval, [63:32] stale_count, [95:64] mismatch_count,
	// [127:96] max_isr_cycles, [159:128] overrun_count, [191:160] max_imu_cycles,
	// [223:192] imu_error_count, [255:224] reset_delay_ticks,
	// [287:256] reset_pulse_delta, [288] reset_measured, [289] line_fresh,
	// [290] monitor_active, [295:291] zero
	output logic [rtm_pkg::OUT_DATA_W-1:0]    m_tdata,
	input  logic                              cfg_we,
	input  logic                              cfg_index,
	input  logic [rtm_pkg::WORD_W-1:0]        cfg_data
);
	import rtm_pkg::*;

	logic [WORD_W-1:0]  overrun_limit_q;
	logic [STALE_W-1:0] stale_limit_q;
	cmd_t               front_cmd;
	cmd_t               head_cmd;
	logic               queue_full;
	logic               queue_not_empty;
	logic               cmd_pop;
	logic               push;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			overrun_limit_q <= OVERRUN_LIMIT_RST;
			stale_limit_q   <= STALE_LIMIT_RST;
		end else if (cfg_we) begin
			if (cfg_index == REG_OVERRUN_LIMIT) begin
				overrun_limit_q <= cfg_data;
			end else begin
				stale_limit_q <= cfg_data[STALE_W-1:0];
			end
		end
	end

	assign s_tready = !queue_full;
	assign push     = s_tvalid && s_tready;

	// Decode of each request.
	rtm_front u_front (
		.req_type      (s_tuser),
		.pulse         (s_tdata[WORD_W-1:0]),
		.cycles        (s_tdata[2*WORD_W-1:WORD_W]),
		.overrun_limit (overrun_limit_q),
		.cmd           (front_cmd)
	);

	// Queue between decode and execution.
	rtm_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_cmd  (front_cmd),
		.full      (queue_full),
		.pop       (cmd_pop),
		.not_empty (queue_not_empty),
		.head_cmd  (head_cmd)
	);

	// Execution of events and the result register.
	rtm_back #(
		.COUNT_BITS (COUNT_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.stale_limit (stale_limit_q),
		.cmd_valid   (queue_not_empty),
		.cmd         (head_cmd),
		.cmd_pop     (cmd_pop),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata)
	);

endmodule

// ----- rtl/core/rtm_front.sv -----
module rtm_front (
	input  logic [rtm_pkg::REQ_W-1:0]  req_type,
	input  logic [rtm_pkg::WORD_W-1:0] pulse,
	input  logic [rtm_pkg::WORD_W-1:0] cycles,
	input  logic [rtm_pkg::WORD_W-1:0] overrun_limit,
	output rtm_pkg::cmd_t              cmd
);
	import rtm_pkg::*;

	op_t op;

	// Map the raw request code onto an operation; unused codes do nothing.
	always_comb begin
		case (req_type)
			REQ_START:    op = OP_START;
			REQ_STOP:     op = OP_STOP;
			REQ_TICK:     op = OP_TICK;
			REQ_LINE:     op = OP_LINE;
			REQ_MISMATCH: op = OP_MISMATCH;
			REQ_MARKER:   op = OP_MARKER;
			REQ_REF_RST:  op = OP_REF_RST;
			REQ_ISR_END:  op = OP_ISR_END;
			REQ_IMU_TIME: op = OP_IMU_TIME;
			REQ_IMU_ERR:  op = OP_IMU_ERR;
			default:      op = OP_NONE;
		endcase
	end

	// The overrun compare is settled here so the back end only counts.
	always_comb begin
		cmd.op         = op;
		cmd.over_limit = (cycles > overrun_limit);
		cmd.pulse      = pulse;
		cmd.cycles     = cycles;
	end

endmodule

// ----- rtl/core/rtm_queue.sv -----
module rtm_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  rtm_pkg::cmd_t push_cmd,
	output logic          full,
	input  logic          pop,
	output logic          not_empty,
	output rtm_pkg::cmd_t head_cmd
);
	import rtm_pkg::*;

	cmd_t                   mem_q [QUEUE_DEPTH];
	logic [QUEUE_PTR_W-1:0] wr_ptr_q;
	logic [QUEUE_PTR_W-1:0] rd_ptr_q;
	logic [QUEUE_CNT_W-1:0] count_q;

	assign full      = (count_q == QUEUE_CNT_W'(QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign head_cmd  = mem_q[rd_ptr_q];

	// Storage of the queued commands.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	// Pointers wrap at the queue depth.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ----- rtl/core/rtm_back.sv -----
module rtm_back #(
	parameter int COUNT_BITS = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic [rtm_pkg::STALE_W-1:0]     stale_limit,
	input  logic                            cmd_valid,
	input  rtm_pkg::cmd_t                   cmd,
	output logic                            cmd_pop,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [rtm_pkg::OUT_DATA_W-1:0]  m_tdata
);
	import rtm_pkg::*;

	localparam int CNT_W = (COUNT_BITS >= 32) ? 32 : COUNT_BITS;
	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

	// Recording state. Tick distances are kept as running ages.
	logic              active_q, active_n;
	logic              line_seen_q, line_seen_n;
	logic              marker_seen_q, marker_seen_n;
	logic              measured_q, measured_n;
	logic [WORD_W-1:0] line_age_q, line_age_n;
	logic [WORD_W-1:0] marker_age_q, marker_age_n;
	logic [WORD_W-1:0] marker_pulse_q, marker_pulse_n;
	logic [WORD_W-1:0] max_interval_q, max_interval_n;
	logic [WORD_W-1:0] max_isr_q, max_isr_n;
	logic [WORD_W-1:0] max_imu_q, max_imu_n;
	logic [WORD_W-1:0] delay_ticks_q, delay_ticks_n;
	logic [WORD_W-1:0] pulse_delta_q, pulse_delta_n;
	logic [CNT_W-1:0]  stale_cnt_q, stale_cnt_n;
	logic [CNT_W-1:0]  mismatch_cnt_q, mismatch_cnt_n;
	logic [CNT_W-1:0]  overrun_cnt_q, overrun_cnt_n;
	logic [CNT_W-1:0]  imu_err_cnt_q, imu_err_cnt_n;

	logic                  fresh_n;
	logic [OUT_DATA_W-1:0] snapshot;
	logic                  out_valid_q;
	logic [OUT_DATA_W-1:0] out_data_q;

	// A command leaves the queue when the output register is free or being taken.
	assign cmd_pop  = cmd_valid && (!out_valid_q || m_tready);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	// Next-state logic for one event.
	always_comb begin
		active_n       = active_q;
		line_seen_n    = line_seen_q;
		marker_seen_n  = marker_seen_q;
		measured_n     = measured_q;
		line_age_n     = line_age_q;
		marker_age_n   = marker_age_q;
		marker_pulse_n = marker_pulse_q;
		max_interval_n = max_interval_q;
		max_isr_n      = max_isr_q;
		max_imu_n      = max_imu_q;
		delay_ticks_n  = delay_ticks_q;
		pulse_delta_n  = pulse_delta_q;
		stale_cnt_n    = stale_cnt_q;
		mismatch_cnt_n = mismatch_cnt_q;
		overrun_cnt_n  = overrun_cnt_q;
		imu_err_cnt_n  = imu_err_cnt_q;

		if (cmd.op == OP_START) begin
			active_n       = 1'b1;
			line_seen_n    = 1'b0;
			marker_seen_n  = 1'b0;
			measured_n     = 1'b0;
			line_age_n     = '0;
			marker_age_n   = '0;
			marker_pulse_n = '0;
			max_interval_n = '0;
			max_isr_n      = '0;
			max_imu_n      = '0;
			delay_ticks_n  = '0;
			pulse_delta_n  = '0;
			stale_cnt_n    = '0;
			mismatch_cnt_n = '0;
			overrun_cnt_n  = '0;
			imu_err_cnt_n  = '0;
		end else if (cmd.op == OP_STOP) begin
			active_n = 1'b0;
		end else if (active_q) begin
			case (cmd.op)
				OP_TICK: begin
					line_age_n   = line_age_q + 1'b1;
					marker_age_n = marker_age_q + 1'b1;
					if (line_age_n > max_interval_q) begin
						max_interval_n = line_age_n;
					end
					if (line_age_n >= WORD_W'(stale_limit) && stale_cnt_q != CNT_MAX) begin
						stale_cnt_n = stale_cnt_q + 1'b1;
					end
				end
				OP_LINE: begin
					if (line_age_q > max_interval_q) begin
						max_interval_n = line_age_q;
					end
					line_age_n  = '0;
					line_seen_n = 1'b1;
				end
				OP_MISMATCH: begin
					if (mismatch_cnt_q != CNT_MAX) begin
						mismatch_cnt_n = mismatch_cnt_q + 1'b1;
					end
				end
				OP_MARKER: begin
					// Only the first marker after start or after a measurement counts.
					if (!marker_seen_q) begin
						marker_age_n   = '0;
						marker_pulse_n = cmd.pulse;
						marker_seen_n  = 1'b1;
					end
				end
				OP_REF_RST: begin
					if (marker_seen_q) begin
						delay_ticks_n = marker_age_q;
						pulse_delta_n = cmd.pulse - marker_pulse_q;
						measured_n    = 1'b1;
						marker_seen_n = 1'b0;
					end
				end
				OP_ISR_END: begin
					if (cmd.cycles > max_isr_q) begin
						max_isr_n = cmd.cycles;
					end
					if (cmd.over_limit && overrun_cnt_q != CNT_MAX) begin
						overrun_cnt_n = overrun_cnt_q + 1'b1;
					end
				end
				OP_IMU_TIME: begin
					if (cmd.cycles > max_imu_q) begin
						max_imu_n = cmd.cycles;
					end
				end
				OP_IMU_ERR: begin
					if (imu_err_cnt_q != CNT_MAX) begin
						imu_err_cnt_n = imu_err_cnt_q + 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Line freshness and the snapshot, both taken after the event.
	always_comb begin
		fresh_n  = !active_n || (line_seen_n && (line_age_n < WORD_W'(stale_limit)));
		snapshot = {
			5'b0,
			active_n,
			fresh_n,
			measured_n,
			pulse_delta_n,
			delay_ticks_n,
			WORD_W'(imu_err_cnt_n),
			max_imu_n,
			WORD_W'(overrun_cnt_n),
			max_isr_n,
			WORD_W'(mismatch_cnt_n),
			WORD_W'(stale_cnt_n),
			max_interval_n
		};
	end

	// State registers advance once per executed command.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q       <= 1'b0;
			line_seen_q    <= 1'b0;
			marker_seen_q  <= 1'b0;
			measured_q     <= 1'b0;
			line_age_q     <= '0;
			marker_age_q   <= '0;
			marker_pulse_q <= '0;
			max_interval_q <= '0;
			max_isr_q      <= '0;
			max_imu_q      <= '0;
			delay_ticks_q  <= '0;
			pulse_delta_q  <= '0;
			stale_cnt_q    <= '0;
			mismatch_cnt_q <= '0;
			overrun_cnt_q  <= '0;
			imu_err_cnt_q  <= '0;
		end else if (cmd_pop) begin
			active_q       <= active_n;
			line_seen_q    <= line_seen_n;
			marker_seen_q  <= marker_seen_n;
			measured_q     <= measured_n;
			line_age_q     <= line_age_n;
			marker_age_q   <= marker_age_n;
			marker_pulse_q <= marker_pulse_n;
			max_interval_q <= max_interval_n;
			max_isr_q      <= max_isr_n;
			max_imu_q      <= max_imu_n;
			delay_ticks_q  <= delay_ticks_n;
			pulse_delta_q  <= pulse_delta_n;
			stale_cnt_q    <= stale_cnt_n;
			mismatch_cnt_q <= mismatch_cnt_n;
			overrun_cnt_q  <= overrun_cnt_n;
			imu_err_cnt_q  <= imu_err_cnt_n;
		end
	end

	// Output register holds the snapshot until the receiver takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd_pop) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			out_data_q <= snapshot;
		end
	end

	// A measurement can only appear through a reference reset.
	a_measured_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(measured_q) |-> $past(cmd_pop && cmd.op == OP_REF_RST))
		else $error("measured flag set without a reference reset");

	// Ticks while stopped leave the stale count alone.
	a_idle_tick: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_pop && !active_q && cmd.op == OP_TICK) |=> $stable(stale_cnt_q))
		else $error("stale count moved while stopped");

	// A snapshot of a stopped monitor always reports the line as fresh.
	a_idle_fresh: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_data_q[290]) |-> out_data_q[289])
		else $error("line reported stale while stopped");

	// A new result only appears after a command was executed.
	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(cmd_pop))
		else $error("result without an executed command");

endmodule
